FILE: rtl/sc_pkg.sv
// Shared constants and types for the scope capture edge trigger block
`default_nettype none
package sc_pkg;

	localparam int BUFFER_DEPTH = 2048;
	localparam int SCREEN_WIDTH = 128;
	localparam int SAMPLE_BITS  = 12;

	localparam int ADDR_W  = $clog2(BUFFER_DEPTH);
	localparam int FILL_W  = ADDR_W + 1;
	localparam int STEP_W  = $clog2(BUFFER_DEPTH / 2);
	localparam int LEVEL_W = 12;
	localparam int ERR_W   = 32;
	localparam int CMP_W   = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

	localparam logic [ADDR_W-1:0] HALF_SCREEN = ADDR_W'((SCREEN_WIDTH / 2) % BUFFER_DEPTH);
	localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(BUFFER_DEPTH / 2 - 1);
	localparam logic [FILL_W-1:0] FILL_FULL   = FILL_W'(BUFFER_DEPTH);

	localparam logic CMD_STORE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic REG_TRIGGER_LEVEL = 1'b0;
	localparam logic REG_EDGE_SELECT   = 1'b1;

	localparam logic EDGE_RISING  = 1'b0;
	localparam logic EDGE_FALLING = 1'b1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [ADDR_W-1:0]      addr_t;

	typedef struct packed {
		logic  valid;
		addr_t index;
		logic  found;
	} search_res_t;

endpackage
`default_nettype wire

FILE: rtl/sc_ram.sv
// Generic simple dual-port RAM with registered read
`default_nettype none
module sc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/sc_cross.sv
// Level crossing detector shared by every step of the trigger walk
`default_nettype none
module sc_cross (
	input  wire logic                         edge_sel,
	input  wire logic [sc_pkg::LEVEL_W-1:0]   level,
	input  wire sc_pkg::sample_t              a,
	input  wire sc_pkg::sample_t              b,
	output logic                              hit
);

	logic [sc_pkg::CMP_W-1:0] a_x, b_x, l_x;

	always_comb begin
		a_x = sc_pkg::CMP_W'(a);
		b_x = sc_pkg::CMP_W'(b);
		l_x = sc_pkg::CMP_W'(level);
		case (edge_sel)
			sc_pkg::EDGE_RISING:  hit = (a_x <= l_x) && (b_x > l_x);
			sc_pkg::EDGE_FALLING: hit = (a_x >= l_x) && (b_x < l_x);
			default:              hit = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/sc_search.sv
// Sequencer that walks the sample buffer backward looking for a crossing
`default_nettype none
module sc_search (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       launch,
	input  wire sc_pkg::addr_t              newest,
	input  wire logic [sc_pkg::LEVEL_W-1:0] level,
	input  wire logic                       edge_sel,
	input  wire sc_pkg::sample_t            rd_sample,
	output sc_pkg::addr_t                   raddr,
	output logic                            busy,
	output sc_pkg::search_res_t             res
);

	typedef enum logic [1:0] {
		SR_IDLE = 2'b01,
		SR_WALK = 2'b10
	} sr_state_t;

	sr_state_t                   state_q;
	sc_pkg::addr_t               start_q, addr_q, pos_q;
	sc_pkg::addr_t               start_pos;
	sc_pkg::sample_t             b_q;
	logic                        first_q;
	logic [sc_pkg::STEP_W-1:0]   step_q;
	logic                        res_valid_q;
	sc_pkg::addr_t               res_index_q;
	logic                        res_found_q;
	logic                        hit;

	assign start_pos = newest - sc_pkg::HALF_SCREEN;
	// read one ahead: the sample after start is needed as the first "b"
	assign raddr = (state_q == SR_IDLE) ? start_pos + sc_pkg::ADDR_W'(1) : addr_q;
	assign busy  = (state_q != SR_IDLE);
	assign res   = '{valid: res_valid_q, index: res_index_q, found: res_found_q};

	sc_cross u_cross (
		.edge_sel (edge_sel),
		.level    (level),
		.a        (rd_sample),
		.b        (b_q),
		.hit      (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SR_IDLE;
			first_q     <= 1'b0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				SR_IDLE: begin
					if (launch) begin
						first_q <= 1'b1;
						step_q  <= '0;
						state_q <= SR_WALK;
					end
				end
				SR_WALK: begin
					first_q <= 1'b0;
					if (!first_q) begin
						if (hit) begin
							res_valid_q <= 1'b1;
							state_q     <= SR_IDLE;
						end else if (step_q == sc_pkg::STEP_LAST) begin
							res_valid_q <= 1'b1;
							state_q     <= SR_IDLE;
						end else begin
							step_q <= step_q + sc_pkg::STEP_W'(1);
						end
					end
				end
				default: state_q <= SR_IDLE;
			endcase
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		case (state_q)
			SR_IDLE: begin
				if (launch) begin
					start_q <= start_pos;
					addr_q  <= start_pos;
				end
			end
			SR_WALK: begin
				pos_q  <= addr_q;
				addr_q <= addr_q - sc_pkg::ADDR_W'(1);
				b_q    <= rd_sample;
				if (!first_q) begin
					if (hit) begin
						res_index_q <= pos_q;
						res_found_q <= 1'b1;
					end else begin
						res_index_q <= start_q;
						res_found_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/scope_capture_edge_trigger.sv
// Top level: sample capture buffer, overflow counter and trigger search
//
// Commands enter on start/busy: a beat is taken at a rising edge with start
// high and busy low. cmd selects a store or a trigger search.
// A store writes sample_value into the next buffer slot and counts
// fifo_overflow; it gives no result, so stores can run back to back at
// one per cycle while no search is busy.
// A search walks the buffer backward from newest minus half a screen, one
// buffer read and one level compare per cycle through a single comparator.
// Its result appears on trigger_index/trigger_found/error_count with done
// high for exactly one cycle when the walk ends. busy stays high for the
// whole walk; the result cannot be held off. Configuration is to be written
// (cfg_we/cfg_addr/cfg_wdata) by the user only while idle; the block does
// not enforce it. Reset sets the level to mid scale, falling edge, clears
// the counter and makes the whole buffer read as zero at once: a fill count
// marks the slots not yet written, so there is no clearing pass.
`default_nettype none
module scope_capture_edge_trigger (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        cmd,
	input  wire sc_pkg::sample_t             sample_value,
	input  wire logic                        fifo_overflow,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_addr,
	input  wire logic [sc_pkg::LEVEL_W-1:0]  cfg_wdata,
	output logic                             done,
	output logic [sc_pkg::ADDR_W-1:0]        trigger_index,
	output logic                             trigger_found,
	output logic [sc_pkg::ERR_W-1:0]         error_count
);

	logic [sc_pkg::LEVEL_W-1:0] level_q;
	logic                       edge_q;
	sc_pkg::addr_t              newest_q;
	logic [sc_pkg::FILL_W-1:0]  fill_q;
	logic [sc_pkg::ERR_W-1:0]   err_q;
	logic                       rd_ok_q;

	logic                       accept, store, launch;
	sc_pkg::addr_t              waddr, raddr;
	sc_pkg::sample_t            ram_rdata, rd_sample;
	sc_pkg::search_res_t        res;

	assign accept = start && !busy;
	assign store  = accept && (cmd == sc_pkg::CMD_STORE);
	assign launch = accept && (cmd == sc_pkg::CMD_SEARCH);
	assign waddr  = newest_q + sc_pkg::ADDR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= sc_pkg::LEVEL_W'(2048);
			edge_q   <= sc_pkg::EDGE_FALLING;
			newest_q <= '1;
			fill_q   <= '0;
			err_q    <= '0;
			rd_ok_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					sc_pkg::REG_TRIGGER_LEVEL: level_q <= cfg_wdata;
					sc_pkg::REG_EDGE_SELECT:   edge_q  <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (store) begin
				newest_q <= waddr;
				if (fill_q != sc_pkg::FILL_FULL) begin
					fill_q <= fill_q + sc_pkg::FILL_W'(1);
				end
				if (fifo_overflow) begin
					err_q <= err_q + sc_pkg::ERR_W'(1);
				end
			end
			// slots are written in order from zero, so anything at or past
			// the fill count has never been written and reads as zero
			rd_ok_q <= (fill_q == sc_pkg::FILL_FULL) || ({1'b0, raddr} < fill_q);
		end
	end

	sc_ram #(
		.WIDTH (sc_pkg::SAMPLE_BITS),
		.DEPTH (sc_pkg::BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (waddr),
		.wdata (sc_pkg::SAMPLE_BITS'(sample_value)),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	assign rd_sample = rd_ok_q ? ram_rdata : '0;

	sc_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.launch    (launch),
		.newest    (newest_q),
		.level     (level_q),
		.edge_sel  (edge_q),
		.rd_sample (rd_sample),
		.raddr     (raddr),
		.busy      (busy),
		.res       (res)
	);

	assign done          = res.valid;
	assign trigger_index = res.index;
	assign trigger_found = res.found;
	assign error_count   = err_q;

endmodule
`default_nettype wire

FILE: sim/scope_capture_edge_trigger_tb.sv
// Self-checking testbench for scope_capture_edge_trigger: sample stores, trigger searches, config
`timescale 1ns / 100ps
`default_nettype none
module scope_capture_edge_trigger_tb;

	typedef struct {
		sc_pkg::addr_t            index;
		logic                     found;
		logic [sc_pkg::ERR_W-1:0] errors;
	} trig_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       cmd = sc_pkg::CMD_STORE;
	logic [11:0]                sample_value = '0;
	logic                       fifo_overflow = 1'b0;
	logic                       cfg_we = 1'b0;
	logic                       cfg_addr = sc_pkg::REG_TRIGGER_LEVEL;
	logic [11:0]                cfg_wdata = '0;
	logic                       busy;
	logic                       done;
	logic [sc_pkg::ADDR_W-1:0]  trigger_index;
	logic                       trigger_found;
	logic [sc_pkg::ERR_W-1:0]   error_count;

	// shadow copy of the capture state
	sc_pkg::sample_t            shadow_samples [sc_pkg::BUFFER_DEPTH];
	sc_pkg::addr_t              shadow_newest;
	logic [sc_pkg::ERR_W-1:0]   shadow_overflows;
	logic [sc_pkg::LEVEL_W-1:0] cur_level;
	logic                       cur_edge;

	trig_result_t       pending_triggers [$];
	trig_result_t       oldest;
	int                 mismatch_count = 0;
	int                 items_sent = 0;
	int                 stores_sent = 0;
	int                 searches_sent = 0;
	int                 crossings_due = 0;
	int                 results_checked = 0;
	int                 settings_used = 0;
	bit                 no_idle = 1'b0;

	scope_capture_edge_trigger DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.sample_value  (sample_value),
		.fifo_overflow (fifo_overflow),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.done          (done),
		.trigger_index (trigger_index),
		.trigger_found (trigger_found),
		.error_count   (error_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void reset_shadow();
		for (int i = 0; i < sc_pkg::BUFFER_DEPTH; i++)
			shadow_samples[i] = '0;
		shadow_newest    = '1;
		shadow_overflows = '0;
		cur_level        = sc_pkg::LEVEL_W'(2048);
		cur_edge         = sc_pkg::EDGE_FALLING;
	endfunction

	// walk back from newest minus half a screen; first crossing wins
	function automatic trig_result_t find_trigger();
		trig_result_t    r;
		sc_pkg::addr_t   from;
		sc_pkg::addr_t   probe;
		sc_pkg::sample_t here;
		sc_pkg::sample_t after;
		bit              hit;
		from     = shadow_newest - sc_pkg::HALF_SCREEN;
		r.index  = from;
		r.found  = 1'b0;
		r.errors = shadow_overflows;
		for (int k = 0; k < sc_pkg::BUFFER_DEPTH / 2; k++) begin
			probe = from - sc_pkg::addr_t'(k);
			here  = shadow_samples[probe];
			after = shadow_samples[sc_pkg::addr_t'(probe + 1'b1)];
			if (cur_edge == sc_pkg::EDGE_RISING)
				hit = (here <= cur_level) && (after > cur_level);
			else
				hit = (here >= cur_level) && (after < cur_level);
			if (hit) begin
				r.index = probe;
				r.found = 1'b1;
				break;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_triggers.size() == 0) begin
				report_mismatch("search result with no search pending");
			end else begin
				oldest = pending_triggers.pop_front();
				results_checked++;
				if (trigger_index !== oldest.index)
					report_mismatch($sformatf("trigger_index %0d, want %0d",
						trigger_index, oldest.index));
				if (trigger_found !== oldest.found)
					report_mismatch($sformatf("trigger_found %0b, want %0b",
						trigger_found, oldest.found));
				if (error_count !== oldest.errors)
					report_mismatch($sformatf("error_count %0d, want %0d",
						error_count, oldest.errors));
			end
		end
	end

	task automatic maybe_idle();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// one command beat; start is left high so the next beat can follow at once
	task automatic send_beat(input logic op, input logic [11:0] value, input logic ovf);
		trig_result_t r;
		maybe_idle();
		start         <= 1'b1;
		cmd           <= op;
		sample_value  <= value;
		fifo_overflow <= ovf;
		do @(posedge clk); while (busy);
		items_sent++;
		if (op == sc_pkg::CMD_STORE) begin
			stores_sent++;
			if (ovf)
				shadow_overflows++;
			shadow_newest++;
			shadow_samples[shadow_newest] = value;
		end else begin
			searches_sent++;
			r = find_trigger();
			if (r.found)
				crossings_due++;
			pending_triggers.push_back(r);
		end
	endtask

	// drain: all results in, block idle, then a wait for a trailing store
	task automatic settle_idle();
		start <= 1'b0;
		while (pending_triggers.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [sc_pkg::LEVEL_W-1:0] level, input logic edge_kind);
		settle_idle();
		cfg_we    <= 1'b1;
		cfg_addr  <= sc_pkg::REG_TRIGGER_LEVEL;
		cfg_wdata <= level;
		@(posedge clk);
		cur_level = level;
		cfg_addr  <= sc_pkg::REG_EDGE_SELECT;
		cfg_wdata <= {11'b0, edge_kind};
		@(posedge clk);
		cur_edge = edge_kind;
		cfg_we   <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [11:0] wave_value(input int kind, input int i, input int period,
			input int delta);
		int v;
		case (kind)
			0: v = $urandom_range(0, 4095);
			1: v = ((i % period) < (period + 1) / 2) ? int'(cur_level) + delta
				: int'(cur_level) - delta;
			2: v = (i * (4096 / period)) % 4096;
			default: v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	// buffer reads as zero after reset; search fields must be ignored
	task automatic test_power_up_search();
		send_beat(sc_pkg::CMD_SEARCH, 12'h000, 1'b0);
		send_beat(sc_pkg::CMD_SEARCH, 12'hFFF, 1'b1);
	endtask

	task automatic test_overflow_count();
		send_beat(sc_pkg::CMD_STORE, 12'hFFF, 1'b1);
		send_beat(sc_pkg::CMD_STORE, 12'h000, 1'b1);
		send_beat(sc_pkg::CMD_STORE, 12'hAAA, 1'b0);
		send_beat(sc_pkg::CMD_STORE, 12'h555, 1'b0);
		send_beat(sc_pkg::CMD_SEARCH, 12'h000, 1'b1);
	endtask

	// extreme levels on both edges: some of these can never fire
	task automatic test_extreme_levels();
		configure(12'd0, sc_pkg::EDGE_RISING);
		send_beat(sc_pkg::CMD_SEARCH, 12'h123, 1'b0);
		configure(12'd4095, sc_pkg::EDGE_RISING);
		send_beat(sc_pkg::CMD_SEARCH, 12'h000, 1'b0);
		configure(12'd0, sc_pkg::EDGE_FALLING);
		send_beat(sc_pkg::CMD_SEARCH, 12'hFFF, 1'b0);
		configure(12'd4095, sc_pkg::EDGE_FALLING);
		send_beat(sc_pkg::CMD_SEARCH, 12'h000, 1'b0);
		for (int i = 0; i < 6; i++)
			send_beat(sc_pkg::CMD_STORE, (i % 2) ? 12'hFFF : 12'h000, i[0]);
		send_beat(sc_pkg::CMD_SEARCH, 12'h7FF, 1'b1);
	endtask

	task automatic run_wave_phase(input int n, input int search_odds);
		int kind;
		int period;
		int delta;
		kind   = $urandom_range(0, 3);
		period = $urandom_range(2, 200);
		delta  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, search_odds) == 0)
				send_beat(sc_pkg::CMD_SEARCH, 12'($urandom), 1'($urandom));
			else
				send_beat(sc_pkg::CMD_STORE, wave_value(kind, i, period, delta),
					($urandom_range(0, 7) == 0));
		end
	endtask

	task automatic test_random_phases();
		logic [sc_pkg::LEVEL_W-1:0] level;
		int                         phase;
		phase = 0;
		while (items_sent < 860) begin
			case (phase % 5)
				0: level = 12'd0;
				1: level = 12'd4095;
				2: level = 12'd2048;
				default: level = 12'($urandom);
			endcase
			configure(level, phase[0]);
			run_wave_phase($urandom_range(30, 90), 11);
			phase++;
		end
	endtask

	// no gaps at all: stores and searches back to back
	task automatic test_back_to_back();
		configure(12'($urandom), 1'($urandom));
		no_idle = 1'b1;
		run_wave_phase(60, 7);
	endtask

	initial begin
		reset_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_up_search();
		test_overflow_count();
		test_extreme_levels();
		test_random_phases();
		test_back_to_back();
		settle_idle();
		repeat (20) @(posedge clk);
		$display("Ran %0d beats: %0d stores, %0d searches over %0d trigger settings.",
			items_sent, stores_sent, searches_sent, settings_used);
		$display("Checked %0d search results, %0d with a crossing; %0d mismatches.",
			results_checked, crossings_due, mismatch_count);
		if (mismatch_count == 0 && pending_triggers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

FILE: scope_capture_edge_trigger.f
rtl/sc_pkg.sv
rtl/sc_ram.sv
rtl/sc_cross.sv
rtl/sc_search.sv
rtl/scope_capture_edge_trigger.sv
sim/scope_capture_edge_trigger_tb.sv
